// ===== rtl/core/vwci_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the VOC word checker.
// Used by the top level, the index calculation, the port monitor and the testbench.
// No dependencies.
package vwci_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CheckW = 8;
  localparam int unsigned IndexW = 9;
  localparam int unsigned CfgIdxW = 2;

  // CRC-8 over the high byte and then the low byte.
  localparam logic [CheckW-1:0] CrcInit = 8'hFF;
  localparam logic [CheckW-1:0] CrcPoly = 8'h31;

  localparam logic [WordW-1:0] BaselineReset = 16'd30000;

  localparam logic [IndexW-1:0] CenterReset  = 9'd100;
  localparam logic [IndexW-1:0] FloorReset   = 9'd1;
  localparam logic [IndexW-1:0] CeilingReset = 9'd500;

  // Division by 50 as a multiplication by ceil(2^22 / 50), exact for any 16-bit magnitude.
  localparam int unsigned       RecipShift = 22;
  localparam int unsigned       RecipW     = 17;
  localparam logic [RecipW-1:0] RecipMult  = 17'd83887;
  localparam int unsigned       QuoW       = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INDEX_CENTER  = 2'd0,
    REG_INDEX_FLOOR   = 2'd1,
    REG_INDEX_CEILING = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [IndexW-1:0] center;
    logic [IndexW-1:0] idx_floor;
    logic [IndexW-1:0] idx_ceiling;
  } index_cfg_t;

  // Payload between the check stage and the index stage.
  typedef struct packed {
    logic             ok;
    logic             neg;
    logic [WordW-1:0] mag;
    logic [WordW-1:0] word;
    logic [WordW-1:0] baseline;
  } mid_t;

  function automatic logic [CheckW-1:0] crc8_byte(logic [CheckW-1:0] crc,
                                                  logic [CheckW-1:0] data);
    logic [CheckW-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[CheckW-1]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/vwci_index_calc.sv =====
// Index calculation: signed difference divided by 50, offset by the centre and clamped.
// Depends on vwci_pkg.
module vwci_index_calc import vwci_pkg::*; (
  input  logic              neg_i,
  input  logic [WordW-1:0]  mag_i,
  input  index_cfg_t        cfg_i,
  output logic [IndexW-1:0] index_o
);

  localparam int unsigned ProdW = WordW + RecipW;
  localparam int unsigned SumW  = 13;

  logic [ProdW-1:0]       prod;
  logic [QuoW-1:0]        quo;
  logic signed [SumW-1:0] quo_s;
  logic signed [SumW-1:0] idx_raw;
  logic signed [SumW-1:0] idx_lo;
  logic signed [SumW-1:0] idx_hi;
  logic signed [SumW-1:0] idx_clamped;

  assign prod  = ProdW'(mag_i) * ProdW'(RecipMult);
  assign quo   = prod[RecipShift +: QuoW];
  assign quo_s = signed'(SumW'(quo));

  // Truncation toward zero: the quotient of the magnitude carries the sign back.
  assign idx_raw = signed'(SumW'(cfg_i.center)) + (neg_i ? -quo_s : quo_s);

  // Floor first, then ceiling, so a floor above the ceiling yields the ceiling.
  always_comb begin
    idx_lo = signed'(SumW'(cfg_i.idx_floor));
    idx_hi = signed'(SumW'(cfg_i.idx_ceiling));
    idx_clamped = idx_raw;
    if (idx_clamped < idx_lo) begin
      idx_clamped = idx_lo;
    end
    if (idx_clamped > idx_hi) begin
      idx_clamped = idx_hi;
    end
  end

  assign index_o = idx_clamped[IndexW-1:0];

endmodule

// ===== rtl/core/voc_word_check_and_index.sv =====
// VOC sensor word checker: CRC-8 check, baseline tracking and air-quality index.
// Depends on vwci_pkg and vwci_index_calc.
//
// Each input beat carries one raw sensor word and the CRC-8 byte that came with it
// (polynomial 0x31, initial value 0xFF, high byte first). Every input beat gives
// exactly one output beat. A word with a bad CRC is reported with word_ok low,
// signal_out and air_index zero, and the baseline unchanged. The first good word
// after reset seeds the baseline; every good word then pulls the baseline toward
// the sample by the signed difference shifted down by BASELINE_SHIFT (truncated
// toward zero), and the index is the centre plus the remaining difference divided
// by 50, clamped to the floor and then to the ceiling. The block takes one beat
// per clock cycle while the output side keeps up. A beat passes the input
// register, the check register and the output register in that order; output
// stalls can hold it back. The baseline is updated as a word leaves the input
// register, so the next word always sees it. The configuration registers
// (centre, floor, ceiling) are written through their own port, which is always
// ready, and must only be changed while no word is in flight.
module voc_word_check_and_index import vwci_pkg::*; #(
  parameter int unsigned BASELINE_SHIFT = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input beats.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WordW-1:0]   raw_word_i,
  input  logic [CheckW-1:0]  check_byte_i,
  // Output beats.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               word_ok_o,
  output logic [WordW-1:0]   signal_out_o,
  output logic [IndexW-1:0]  air_index_o,
  output logic [WordW-1:0]   baseline_now_o,
  // Configuration writes.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [IndexW-1:0]  cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to an index beyond the ceiling are dropped.
  // ---------------------------------------------------------------------------
  index_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center      <= CenterReset;
      cfg_q.idx_floor   <= FloorReset;
      cfg_q.idx_ceiling <= CeilingReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_idx_e'(cfg_index_i))
        REG_INDEX_CENTER:  cfg_q.center      <= cfg_data_i;
        REG_INDEX_FLOOR:   cfg_q.idx_floor   <= cfg_data_i;
        REG_INDEX_CEILING: cfg_q.idx_ceiling <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves on when the stage after it is empty
  // or emptying in the same cycle, so a full pipeline still takes a beat every
  // cycle while the output side keeps up.
  // ---------------------------------------------------------------------------
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic out_free, s1_free, s0_free;
  logic s0_move;
  logic in_beat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign s0_free  = !s0_valid_q || s1_free;
  assign s0_move  = s0_valid_q && s1_free;

  assign in_stall_o  = !s0_free;
  assign in_beat     = in_valid_i && s0_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_free) begin
        s0_valid_q <= in_valid_i;
      end
      if (s1_free) begin
        s1_valid_q <= s0_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register.
  // ---------------------------------------------------------------------------
  logic [WordW-1:0]  word_q;
  logic [CheckW-1:0] check_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      word_q  <= raw_word_i;
      check_q <= check_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Check stage: CRC, baseline update and the difference left after the update.
  // With d = sample - baseline and q = d / 2^BASELINE_SHIFT (toward zero), the
  // new baseline is baseline + q and the remaining difference is d - q, which
  // has the sign of d and magnitude |d| - |q|.
  // ---------------------------------------------------------------------------
  logic [WordW-1:0]  baseline_q, baseline_d;
  logic              seeded_q, seeded_d;
  logic [CheckW-1:0] crc_hi, crc_full;
  logic              crc_ok;
  logic [WordW-1:0]  base_eff;
  logic [WordW:0]    diff;
  logic [WordW:0]    diff_abs;
  logic              diff_neg;
  logic [WordW-1:0]  diff_mag;
  logic [WordW-1:0]  step_mag;
  logic [WordW-1:0]  base_new;
  mid_t              mid_d, mid_q;

  assign crc_hi   = crc8_byte(CrcInit, word_q[WordW-1:CheckW]);
  assign crc_full = crc8_byte(crc_hi, word_q[CheckW-1:0]);
  assign crc_ok   = (crc_full == check_q);

  // Before the first good word the sample itself is the baseline.
  assign base_eff = seeded_q ? baseline_q : word_q;
  assign diff     = {1'b0, word_q} - {1'b0, base_eff};
  assign diff_neg = diff[WordW];
  assign diff_abs = diff_neg ? ((WordW+1)'(0) - diff) : diff;
  assign diff_mag = diff_abs[WordW-1:0];
  assign step_mag = diff_mag >> BASELINE_SHIFT;
  assign base_new = diff_neg ? (base_eff - step_mag) : (base_eff + step_mag);

  always_comb begin
    baseline_d = baseline_q;
    seeded_d   = seeded_q;
    if (s0_move && crc_ok) begin
      baseline_d = base_new;
      seeded_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= BaselineReset;
      seeded_q   <= 1'b0;
    end else begin
      baseline_q <= baseline_d;
      seeded_q   <= seeded_d;
    end
  end

  always_comb begin
    mid_d.ok       = crc_ok;
    mid_d.neg      = diff_neg;
    mid_d.mag      = diff_mag - step_mag;
    mid_d.word     = word_q;
    mid_d.baseline = crc_ok ? base_new : baseline_q;
  end

  always_ff @(posedge clk_i) begin
    if (s0_move) begin
      mid_q <= mid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Index stage and output register.
  // ---------------------------------------------------------------------------
  logic [IndexW-1:0] index_val;
  logic              word_ok_q;
  logic [WordW-1:0]  signal_q;
  logic [IndexW-1:0] air_index_q;
  logic [WordW-1:0]  baseline_now_q;

  vwci_index_calc u_index_calc (
    .neg_i   (mid_q.neg),
    .mag_i   (mid_q.mag),
    .cfg_i   (cfg_q),
    .index_o (index_val)
  );

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_free) begin
      word_ok_q      <= mid_q.ok;
      signal_q       <= mid_q.ok ? mid_q.word : '0;
      air_index_q    <= mid_q.ok ? index_val : '0;
      baseline_now_q <= mid_q.baseline;
    end
  end

  assign word_ok_o      = word_ok_q;
  assign signal_out_o   = signal_q;
  assign air_index_o    = air_index_q;
  assign baseline_now_o = baseline_now_q;

endmodule

// ===== rtl/core/vwci_monitor.sv =====
// Port-level monitor for the VOC word checker, with the bind that attaches it.
// Depends on vwci_pkg and the top level's port list.
module vwci_monitor import vwci_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               word_ok_o,
  input logic [WordW-1:0]   signal_out_o,
  input logic [IndexW-1:0]  air_index_o,
  input logic [WordW-1:0]   baseline_now_o
);

  logic             out_beat;
  logic [WordW-1:0] last_base_q;
  logic             seen_ok_q;

  assign out_beat = out_valid_o && !out_stall_i;

  // Baseline as of the last delivered beat, and whether a good word has gone out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_base_q <= BaselineReset;
      seen_ok_q   <= 1'b0;
    end else if (out_beat) begin
      last_base_q <= baseline_now_o;
      seen_ok_q   <= seen_ok_q || word_ok_o;
    end
  end

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_ok_o)
      && $stable(signal_out_o) && $stable(air_index_o) && $stable(baseline_now_o))
    else $error("stalled result beat changed");

  // A CRC error clears the data fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !word_ok_o |-> signal_out_o == '0 && air_index_o == '0)
    else $error("CRC error beat carries data");

  // A CRC error leaves the baseline where the previous beat left it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !word_ok_o |-> baseline_now_o == last_base_q)
    else $error("baseline moved on a CRC error");

  // The first good word seeds the baseline with itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && word_ok_o && !seen_ok_q |-> baseline_now_o == signal_out_o)
    else $error("first good word did not seed the baseline");

endmodule

bind voc_word_check_and_index vwci_monitor u_monitor (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .word_ok_o      (word_ok_o),
  .signal_out_o   (signal_out_o),
  .air_index_o    (air_index_o),
  .baseline_now_o (baseline_now_o)
);

// ===== bench/voc_word_check_and_index_test.sv =====
// Self-checking testbench for voc_word_check_and_index: CRC-8 word check, baseline
// tracking and clamped air-quality index, predicted beat by beat in the bench.
// Depends on vwci_pkg and the RTL of voc_word_check_and_index.
module voc_word_check_and_index_test;
  import vwci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Must match the shift the block is built with.
  localparam int unsigned BaselineShift = 12;
  localparam int          IndexDivisor  = 50;
  // The register port is two bits wide, so index three exists but selects nothing.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  localparam int RandomPhases  = 6;
  localparam int ItemsPerPhase = 100;
  // Idle time after the last reading before the registers change, a generous margin.
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;

  // One input beat: the sensor word and the CRC byte that came with it.
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CheckW-1:0] check;
  } sensor_beat_t;

  // One output beat, field by field as the block presents it.
  typedef struct packed {
    logic              word_ok;
    logic [WordW-1:0]  signal_out;
    logic [IndexW-1:0] air_index;
    logic [WordW-1:0]  baseline_now;
  } reading_t;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [WordW-1:0]   raw_word_i   = '0;
  logic [CheckW-1:0]  check_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               word_ok_o;
  logic [WordW-1:0]   signal_out_o;
  logic [IndexW-1:0]  air_index_o;
  logic [WordW-1:0]   baseline_now_o;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [IndexW-1:0]  cfg_data_i   = '0;

  // Words waiting to be offered, and the readings the block still owes us.
  sensor_beat_t pending_words[$];
  reading_t     index_expected[$];

  // The bench's own copy of the block's registers and tracking state.
  logic [IndexW-1:0] cfg_center  = CenterReset;
  logic [IndexW-1:0] cfg_floor   = FloorReset;
  logic [IndexW-1:0] cfg_ceiling = CeilingReset;
  logic [WordW-1:0]  base_level  = BaselineReset;
  logic              base_seeded = 1'b0;

  // Set by the stimulus: quiet turns all idling off, hold_ask starts the long hold-off.
  logic quiet    = 1'b0;
  logic hold_ask = 1'b0;
  logic hold_done = 1'b0;

  // Set at each rising edge when an input beat was taken; read by the driver.
  logic in_fire = 1'b0;

  int mismatches     = 0;
  int words_checked  = 0;
  int crc_errors     = 0;
  int clamped_words  = 0;
  int reg_writes     = 0;
  int backpressure   = 0;

  voc_word_check_and_index #(
    .BASELINE_SHIFT(BaselineShift)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_word_i    (raw_word_i),
    .check_byte_i  (check_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_ok_o     (word_ok_o),
    .signal_out_o  (signal_out_o),
    .air_index_o   (air_index_o),
    .baseline_now_o(baseline_now_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // CRC-8, polynomial 0x31, initial value 0xFF, fed one bit at a time from the
  // most significant bit of the word, which is the high byte first on the wire.
  function automatic logic [CheckW-1:0] crc_of(input logic [WordW-1:0] word);
    logic [CheckW-1:0] crc;
    logic              feedback;
    crc = CrcInit;
    for (int i = WordW - 1; i >= 0; i--) begin
      feedback = crc[CheckW-1] ^ word[i];
      crc = {crc[CheckW-2:0], 1'b0} ^ (feedback ? CrcPoly : '0);
    end
    return crc;
  endfunction

  // Works out the reading the block owes for one accepted beat and queues it.
  // A bad CRC leaves the state alone and reports the baseline as it stands.
  task automatic track_reading(input logic [WordW-1:0] word, input logic [CheckW-1:0] check);
    reading_t reading;
    int       diff;
    int       level;
    reading = '0;
    reading.baseline_now = base_level;
    words_checked++;
    if (crc_of(word) == check) begin
      if (!base_seeded) begin
        base_level  = word;
        base_seeded = 1'b1;
      end
      // Integer division truncates toward zero, as the tracking filter requires.
      diff = int'(word) - int'(base_level);
      base_level = 16'(int'(base_level) + diff / (1 << BaselineShift));
      level = int'(cfg_center) + (int'(word) - int'(base_level)) / IndexDivisor;
      // Floor first and ceiling second, so a floor above the ceiling yields the ceiling.
      if (level < int'(cfg_floor)) begin
        level = int'(cfg_floor);
        clamped_words++;
      end
      if (level > int'(cfg_ceiling)) begin
        level = int'(cfg_ceiling);
        clamped_words++;
      end
      reading.word_ok      = 1'b1;
      reading.signal_out   = word;
      reading.air_index    = level[IndexW-1:0];
      reading.baseline_now = base_level;
    end else begin
      crc_errors++;
    end
    index_expected.push_back(reading);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("tb: mismatch at %0t ns: %s", $time, msg);
  endtask

  // Input acceptance, prediction and output checking all happen at the rising
  // edge, on values that were driven at the previous falling edge.
  always @(posedge clk_i) begin : scoreboard
    reading_t got;
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{word_ok_o, signal_out_o, air_index_o, baseline_now_o};
      if (index_expected.size() == 0) begin
        flag_mismatch($sformatf("reading with nothing outstanding: %p", got));
      end else begin
        want = index_expected.pop_front();
        if (got.word_ok !== want.word_ok) begin
          flag_mismatch($sformatf("word_ok %b, expected %b", got.word_ok, want.word_ok));
        end
        if (got.signal_out !== want.signal_out) begin
          flag_mismatch($sformatf("signal_out %0d, expected %0d",
                                  got.signal_out, want.signal_out));
        end
        if (got.air_index !== want.air_index) begin
          flag_mismatch($sformatf("air_index %0d, expected %0d",
                                  got.air_index, want.air_index));
        end
        if (got.baseline_now !== want.baseline_now) begin
          flag_mismatch($sformatf("baseline_now %0d, expected %0d",
                                  got.baseline_now, want.baseline_now));
        end
      end
    end
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      track_reading(raw_word_i, check_byte_i);
    end
    if (rst_ni && in_valid_i && in_stall_o) begin
      backpressure++;
    end
  end

  // Sender. A beat stays on the bus, unchanged, until it is taken; only then may
  // the next one go out or an idle burst begin. The chance of a burst is
  // re-rolled now and then, so some stretches carry no gaps at all.
  int feed_gap  = 0;
  int feed_odds = 0;

  always @(negedge clk_i) begin : driver
    sensor_beat_t beat;
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 2))
        0:       feed_odds = 0;
        1:       feed_odds = 15;
        default: feed_odds = 40;
      endcase
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (feed_gap > 0 && !quiet) begin
        feed_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0 && !quiet
                   && $urandom_range(0, 99) < feed_odds) begin
        feed_gap = $urandom_range(1, 14) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        beat = pending_words.pop_front();
        in_valid_i   <= 1'b1;
        raw_word_i   <= beat.word;
        check_byte_i <= beat.check;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. Random stall bursts, and once per run a long hold-off that is
  // counted here while the sender keeps offering, so the block fills up and
  // has to stall its input.
  int drain_gap  = 0;
  int drain_odds = 0;
  int hold_count = 0;

  always @(negedge clk_i) begin : receiver
    if ($urandom_range(0, 63) == 0) begin
      case ($urandom_range(0, 2))
        0:       drain_odds = 0;
        1:       drain_odds = 15;
        default: drain_odds = 40;
      endcase
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_ask && !hold_done) begin
      hold_count++;
      if (hold_count >= HoldCycles) begin
        hold_done = 1'b1;
      end
      out_stall_i <= 1'b1;
    end else if (drain_gap > 0 && !quiet) begin
      drain_gap--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < drain_odds) begin
      drain_gap = $urandom_range(1, 14) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Register write through the configuration port. The bench copy follows the
  // write only once the handshake has completed; index three changes nothing.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IndexW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INDEX_CENTER:  cfg_center  = value;
      REG_INDEX_FLOOR:   cfg_floor   = value;
      REG_INDEX_CEILING: cfg_ceiling = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic offer(input logic [WordW-1:0] word, input logic [CheckW-1:0] check);
    pending_words.push_back('{word, check});
  endtask

  // Waits until every queued word has been taken and every reading has come
  // back, then lets the pipeline run empty before the registers may change.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid_i || index_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [IndexW-1:0] center;
    logic [IndexW-1:0] low_lim;
    logic [IndexW-1:0] high_lim;
    logic [WordW-1:0]  aim;
    logic [WordW-1:0]  word;
    int                spread;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset settings. The first beats carry bad CRCs,
    // so the untouched reset baseline must be reported before any seeding.
    offer(16'h1234, crc_of(16'h1234) ^ 8'h01);
    offer(16'h0000, crc_of(16'h0000) ^ 8'hFF);
    offer(16'h8000, crc_of(16'h8000));
    offer(16'hFFFF, crc_of(16'hFFFF));
    offer(16'h0000, crc_of(16'h0000));
    offer(16'hFFFF, crc_of(16'hFFFF) ^ 8'h80);
    offer(16'h8000, crc_of(16'h8000));
    offer(16'h7FFF, 8'h00);
    offer(16'h5A5A, 8'hFF);
    settle();

    // Lowest centre and floor with the widest ceiling: large negative swings
    // must land on a zero floor.
    write_reg(REG_INDEX_CENTER, '0);
    write_reg(REG_INDEX_FLOOR, '0);
    write_reg(REG_INDEX_CEILING, '1);
    offer(16'h0000, crc_of(16'h0000));
    offer(16'hFFFF, crc_of(16'hFFFF));
    offer(16'h8000, crc_of(16'h8000));
    settle();

    // Everything at the top of the 9-bit field.
    write_reg(REG_INDEX_CENTER, '1);
    write_reg(REG_INDEX_FLOOR, '1);
    write_reg(REG_INDEX_CEILING, '1);
    offer(16'h8000, crc_of(16'h8000));
    offer(16'h0001, crc_of(16'h0001));
    settle();

    // Floor above ceiling: the ceiling wins.
    write_reg(REG_INDEX_CENTER, 9'd300);
    write_reg(REG_INDEX_FLOOR, 9'd400);
    write_reg(REG_INDEX_CEILING, 9'd200);
    offer(16'h8000, crc_of(16'h8000));
    offer(16'hC000, crc_of(16'hC000));
    settle();

    // A write to the spare index must leave all three registers alone.
    write_reg(REG_INDEX_CEILING, CeilingReset);
    write_reg(RegSpare, '1);
    offer(16'h8123, crc_of(16'h8123));
    offer(16'h7EDC, crc_of(16'h7EDC));
    settle();

    // Random part: a new register setting per phase, mostly good words clustered
    // around a drifting level so the index swings across both clamps, with
    // uniform words and bad CRCs mixed in.
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          center = CenterReset; low_lim = FloorReset; high_lim = CeilingReset;
        end
        1: begin
          center = 9'd255; low_lim = '0; high_lim = '1;
        end
        default: begin
          center   = 9'($urandom_range(0, 511));
          low_lim  = 9'($urandom_range(0, 300));
          high_lim = 9'($urandom_range(150, 511));
        end
      endcase
      if (p == 3) begin
        write_reg(RegSpare, 9'($urandom_range(0, 511)));
      end
      write_reg(REG_INDEX_CENTER, center);
      write_reg(REG_INDEX_FLOOR, low_lim);
      write_reg(REG_INDEX_CEILING, high_lim);
      if (p == 2) begin
        hold_ask = 1'b1;
      end
      if (p == RandomPhases - 1) begin
        quiet = 1'b1;
      end
      aim = 16'($urandom);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          aim = 16'($urandom);
        end
        spread = ($urandom_range(0, 3) == 0) ? 30000 : $urandom_range(0, 12000);
        if ($urandom_range(0, 99) < 60) begin
          word = aim + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
        end else begin
          word = 16'($urandom);
        end
        if ($urandom_range(0, 99) < 85) begin
          offer(word, crc_of(word));
        end else if ($urandom_range(0, 1) == 0) begin
          offer(word, crc_of(word) ^ (8'h01 << $urandom_range(0, 7)));
        end else begin
          offer(word, 8'($urandom));
        end
      end
      if (p == 2) begin
        wait (hold_done);
      end
      settle();
    end

    $display("tb: %0d words checked, %0d with CRC errors, %0d clamped indices",
             words_checked, crc_errors, clamped_words);
    $display("tb: %0d register writes, %0d cycles of input back-pressure",
             reg_writes, backpressure);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/vwci_pkg.sv
rtl/core/vwci_index_calc.sv
rtl/core/voc_word_check_and_index.sv
rtl/core/vwci_monitor.sv
bench/voc_word_check_and_index_test.sv
